/* hw/rtl/sled_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sled_pkg: shared types and constants of the frame deframer
// Result codes, frame position constants, configuration and result records.
// ----------------------------------------------------------------------------
package sled_pkg;

   // Result kinds carried on the result channel.
   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_BYTE    = 2'd0;
   localparam logic [1:0] CSR_END_BYTE      = 2'd1;
   localparam logic [1:0] CSR_MAX_FRAME_LEN = 2'd2;

   // Register reset values.
   localparam logic [7:0]  START_BYTE_RESET    = 8'hAA;
   localparam logic [7:0]  END_BYTE_RESET      = 8'hBB;
   localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'd1030;

   // Fixed frame layout.
   localparam logic [15:0] MIN_FRAME_LEN = 16'd5;
   localparam logic [15:0] POS_LEN_HIGH  = 16'd1;
   localparam logic [15:0] POS_LEN_LOW   = 16'd2;
   localparam logic [15:0] POS_COMMAND   = 16'd3;

   // Active configuration seen by the parser.
   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [15:0] max_frame_len;
   } cfg_type;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] position;
      logic [7:0]  command;
      logic [15:0] frame_len;
   } result_type;

endpackage

/* hw/rtl/sof_length_eof_frame_deframer_core.sv */
`timescale 1ns / 1ps
// Results are registered in the output register, or in the skid register if the
// output is stalled. Throughput: one byte per cycle while the skid is empty; the
// output register and the one-entry skid keep req_tready a plain register output.
// Reset: synchronous, active high; the deframer returns to hunting, the
// output and skid registers empty, and the registers take their default values.
// ----------------------------------------------------------------------------
// sof_length_eof_frame_deframer_core: length-prefixed frame deframer
// Accepts received bytes, tracks frames opened by the start byte, emits each
// frame byte and a good/bad verdict on the last byte or on a bad length.
// ----------------------------------------------------------------------------
module sof_length_eof_frame_deframer_core (
   input  logic        clock,
   input  logic        reset,
   // Byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] data_byte, [23:8] position,
                                    // [31:24] command, [47:32] frame_len
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic                 accept;
   logic                 has_result;
   logic                 produce;
   logic                 out_free;
   sled_pkg::result_type result;
   sled_pkg::cfg_type    cfg_ff;
   sled_pkg::result_type rsp_ff;
   sled_pkg::result_type skid_ff;
   logic                 rsp_valid_ff;
   logic                 skid_valid_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= sled_pkg::START_BYTE_RESET;
         cfg_ff.end_byte      <= sled_pkg::END_BYTE_RESET;
         cfg_ff.max_frame_len <= sled_pkg::MAX_FRAME_LEN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sled_pkg::CSR_START_BYTE:    cfg_ff.start_byte    <= csr_data[7:0];
            sled_pkg::CSR_END_BYTE:      cfg_ff.end_byte      <= csr_data[7:0];
            sled_pkg::CSR_MAX_FRAME_LEN: cfg_ff.max_frame_len <= csr_data;
            default: ;
         endcase
      end
   end

   // Input side: stall only when the skid register is holding a result.
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign produce    = accept && has_result;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   sled_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_tdata),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .result     (result)
   );

   // Output register with skid: a result that finds the output stalled waits
   // in the skid register and moves forward on the next transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= produce;
         end
      end else if (produce) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (!out_free && produce) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.frame_len, rsp_ff.command, rsp_ff.position, rsp_ff.data_byte};
   assign rsp_tuser  = rsp_ff.kind;

`ifndef NO_ASSERTIONS
   // The skid register only holds a result behind a full output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while the output register is empty");

   // The skid register fills only when the output was stalled.
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_tready))
      else $error("skid filled without an output stall");

   // A good verdict sits on the last position of a frame of legal length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == sled_pkg::KIND_GOOD) |->
      (rsp_ff.frame_len >= sled_pkg::MIN_FRAME_LEN &&
       ({1'b0, rsp_ff.position} + 17'd1) == {1'b0, rsp_ff.frame_len}))
      else $error("good verdict off the last frame position");

   // A frame byte result never carries command or length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == sled_pkg::KIND_BYTE) |->
      (rsp_ff.command == 8'd0 && rsp_ff.frame_len == 16'd0))
      else $error("frame byte result carries verdict fields");
`endif

endmodule

/* hw/rtl/sled_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sled_parser: frame tracking state and per-byte decision
// Holds the hunting/in-frame state, byte count, length and command, and
// decides combinationally what result, if any, an accepted byte produces.
// ----------------------------------------------------------------------------
module sled_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  sled_pkg::cfg_type    cfg,
   output logic                 has_result,
   output sled_pkg::result_type result
);

   logic        in_frame_ff,     in_frame_in;
   logic [15:0] byte_count_ff,   byte_count_in;
   logic [15:0] length_seen_ff,  length_seen_in;
   logic [7:0]  command_seen_ff, command_seen_in;
   logic [15:0] full_len;
   logic [16:0] pos_plus_one;

   assign full_len     = {length_seen_ff[15:8], rx_byte};
   assign pos_plus_one = {1'b0, byte_count_ff} + 17'd1;

   // Decide the result and the next frame state for the byte at the input.
   always_comb begin
      in_frame_in      = in_frame_ff;
      byte_count_in    = byte_count_ff;
      length_seen_in   = length_seen_ff;
      command_seen_in  = command_seen_ff;
      has_result       = 1'b0;
      result.kind      = sled_pkg::KIND_BYTE;
      result.data_byte = rx_byte;
      result.position  = byte_count_ff;
      result.command   = 8'd0;
      result.frame_len = 16'd0;
      if (accept) begin
         if (!in_frame_ff) begin
            // Hunting: only the start byte opens a frame.
            if (rx_byte == cfg.start_byte) begin
               in_frame_in     = 1'b1;
               byte_count_in   = 16'd1;
               length_seen_in  = 16'd0;
               command_seen_in = 8'd0;
               has_result      = 1'b1;
               result.position = 16'd0;
            end
         end else begin
            has_result    = 1'b1;
            byte_count_in = pos_plus_one[15:0];
            if (byte_count_ff == sled_pkg::POS_LEN_HIGH) begin
               length_seen_in = {rx_byte, 8'h00};
            end else if (byte_count_ff == sled_pkg::POS_LEN_LOW) begin
               // Length is complete; reject out-of-range lengths at once.
               length_seen_in = full_len;
               if (full_len < sled_pkg::MIN_FRAME_LEN || full_len > cfg.max_frame_len) begin
                  in_frame_in      = 1'b0;
                  result.kind      = sled_pkg::KIND_BAD;
                  result.frame_len = full_len;
               end
            end else if (byte_count_ff == sled_pkg::POS_COMMAND) begin
               command_seen_in = rx_byte;
            end else if (pos_plus_one == {1'b0, length_seen_ff}) begin
               // Last byte of the frame: verdict on the end byte.
               in_frame_in      = 1'b0;
               result.kind      = (rx_byte == cfg.end_byte) ? sled_pkg::KIND_GOOD
                                                            : sled_pkg::KIND_BAD;
               result.command   = command_seen_ff;
               result.frame_len = length_seen_ff;
            end
         end
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         byte_count_ff   <= 16'd0;
         length_seen_ff  <= 16'd0;
         command_seen_ff <= 8'd0;
      end else begin
         in_frame_ff     <= in_frame_in;
         byte_count_ff   <= byte_count_in;
         length_seen_ff  <= length_seen_in;
         command_seen_ff <= command_seen_in;
      end
   end

endmodule

/* tb/sv/sof_length_eof_frame_deframer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_length_eof_frame_deframer_core_tb: self-checking deframer testbench
// Drives byte streams built from well-formed frames, bad lengths and line
// noise under several register settings. A scoreboard predicts every frame
// byte and verdict and compares them field by field with the result channel.
// ----------------------------------------------------------------------------

// Predicts the deframer output and holds the results still to arrive.
class frame_scoreboard;
   logic [7:0]           start_byte;
   logic [7:0]           end_byte;
   logic [15:0]          max_frame_len;
   bit                   in_frame;
   logic [15:0]          byte_count;
   logic [15:0]          length_seen;
   logic [7:0]           command_seen;
   sled_pkg::result_type awaited_q[$];
   int                   mismatches;
   int                   results_checked;
   int                   good_frames;
   int                   bad_frames;

   function new();
      start_byte    = sled_pkg::START_BYTE_RESET;
      end_byte      = sled_pkg::END_BYTE_RESET;
      max_frame_len = sled_pkg::MAX_FRAME_LEN_RESET;
      in_frame      = 1'b0;
      byte_count    = '0;
      length_seen   = '0;
      command_seen  = '0;
   endfunction

   function int pending();
      return awaited_q.size();
   endfunction

   function void write_reg(logic [1:0] index, logic [15:0] value);
      case (index)
         sled_pkg::CSR_START_BYTE:    start_byte    = value[7:0];
         sled_pkg::CSR_END_BYTE:      end_byte      = value[7:0];
         sled_pkg::CSR_MAX_FRAME_LEN: max_frame_len = value;
         default: ;
      endcase
   endfunction

   function void push(sled_pkg::kind_type kind, logic [7:0] b, logic [15:0] pos,
                      logic [7:0] cmd, logic [15:0] len);
      sled_pkg::result_type r;
      r.kind      = kind;
      r.data_byte = b;
      r.position  = pos;
      r.command   = cmd;
      r.frame_len = len;
      awaited_q   = {awaited_q, r};
   endfunction

   // Steps the frame parser by one accepted byte.
   function void note_byte(logic [7:0] b);
      logic [15:0] pos;
      if (!in_frame) begin
         if (b != start_byte)
            return;
         in_frame     = 1'b1;
         byte_count   = 16'd1;
         length_seen  = '0;
         command_seen = '0;
         push(sled_pkg::KIND_BYTE, b, 16'd0, 8'd0, 16'd0);
         return;
      end
      pos        = byte_count;
      byte_count = pos + 16'd1;
      if (pos == sled_pkg::POS_LEN_HIGH) begin
         length_seen = {b, 8'h00};
         push(sled_pkg::KIND_BYTE, b, pos, 8'd0, 16'd0);
      end else if (pos == sled_pkg::POS_LEN_LOW) begin
         length_seen = length_seen | {8'h00, b};
         if (length_seen < sled_pkg::MIN_FRAME_LEN || length_seen > max_frame_len) begin
            in_frame = 1'b0;
            push(sled_pkg::KIND_BAD, b, pos, 8'd0, length_seen);
         end else begin
            push(sled_pkg::KIND_BYTE, b, pos, 8'd0, 16'd0);
         end
      end else if (pos == sled_pkg::POS_COMMAND) begin
         command_seen = b;
         push(sled_pkg::KIND_BYTE, b, pos, 8'd0, 16'd0);
      end else if ({1'b0, pos} + 17'd1 == {1'b0, length_seen}) begin
         // Last byte of the frame: the verdict depends on the end byte.
         in_frame = 1'b0;
         push((b == end_byte) ? sled_pkg::KIND_GOOD : sled_pkg::KIND_BAD, b, pos,
              command_seen, length_seen);
      end else begin
         push(sled_pkg::KIND_BYTE, b, pos, 8'd0, 16'd0);
      end
   endfunction

   // Compares one result transaction with the oldest prediction.
   function void check_result(sled_pkg::kind_type kind, logic [7:0] b, logic [15:0] pos,
                              logic [7:0] cmd, logic [15:0] len);
      sled_pkg::result_type want;
      results_checked++;
      if (kind == sled_pkg::KIND_GOOD)
         good_frames++;
      if (kind == sled_pkg::KIND_BAD)
         bad_frames++;
      if (awaited_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected result kind=%0d byte=%02h pos=%0d cmd=%02h len=%0d",
                     kind, b, pos, cmd, len);
         return;
      end
      want = awaited_q[0];
      awaited_q.delete(0);
      if (want.kind !== kind || want.data_byte !== b || want.position !== pos ||
          want.command !== cmd || want.frame_len !== len) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: result differs; expected kind=%0d byte=%02h pos=%0d ",
                     want.kind, want.data_byte, want.position,
                     "cmd=%02h len=%0d, ", want.command, want.frame_len,
                     "got kind=%0d byte=%02h pos=%0d cmd=%02h len=%0d",
                     kind, b, pos, cmd, len);
      end
   endfunction
endclass

module sof_length_eof_frame_deframer_core_tb;

   localparam int         CYCLE_LIMIT  = 600000;
   localparam int         SETTLE_TIME  = 4;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [7:0] data_byte, [23:8] position,
                                      // [31:24] command, [47:32] frame_len
   logic [1:0]  rsp_tuser;            // [1:0] kind
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = 2'd0;
   logic [15:0] csr_data   = 16'h0000;

   frame_scoreboard sb = new();

   // Generator copy of the active settings.
   logic [7:0]  cfg_start = sled_pkg::START_BYTE_RESET;
   logic [7:0]  cfg_end   = sled_pkg::END_BYTE_RESET;
   logic [15:0] cfg_max   = sled_pkg::MAX_FRAME_LEN_RESET;

   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int frame_items = 0;
   int settings_used = 1;
   int cycles = 0;

   sof_length_eof_frame_deframer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sof_length_eof_frame_deframer_core: mismatch");
         $finish;
      end
   end

   // Monitor: every transaction on the three channels goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(sled_pkg::kind_type'(rsp_tuser), rsp_tdata[7:0],
                            rsp_tdata[23:8], rsp_tdata[31:24], rsp_tdata[47:32]);
      end
   end

   // Result side: random stalls before each transaction.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid)
            @(posedge clock);
      end
   end

   // Sends one byte; valid stays high after the transaction.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Writes one register; valid stays high after the transaction.
   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // Writes all registers; the upper bits of the byte registers carry noise.
   task automatic configure(input logic [7:0] s, input logic [7:0] e,
                            input logic [15:0] m);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      write_reg(sled_pkg::CSR_START_BYTE, {junk, s});
      junk = 8'($urandom_range(0, 255));
      write_reg(sled_pkg::CSR_END_BYTE, {junk, e});
      write_reg(sled_pkg::CSR_MAX_FRAME_LEN, m);
      csr_valid <= 1'b0;
      cfg_start = s;
      cfg_end   = e;
      cfg_max   = m;
      settings_used++;
   endtask

   // Stops the input and waits until every predicted result has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   task automatic send_noise(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         b = 8'($urandom_range(0, 255));
         while (b == cfg_start)
            b = 8'($urandom_range(0, 255));
         send_byte(b);
      end
   endtask

   // One random frame, a rejected header or noise; forced_len > 0 forces a frame
   // of that length, whose end byte may still be wrong.
   task automatic send_frame(input int forced_len);
      int         pick;
      int         len;
      int         top;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (forced_len == 0 && (cfg_max < sled_pkg::MIN_FRAME_LEN || pick < 15)) begin
         // Header with a length that is rejected on the low length byte.
         if (cfg_max < sled_pkg::MIN_FRAME_LEN)
            len = $urandom_range(0, 65535);
         else if (cfg_max == 16'hFFFF || pick < 6)
            len = $urandom_range(0, sled_pkg::MIN_FRAME_LEN - 1);
         else
            len = $urandom_range(cfg_max + 1, 65535);
         send_byte(cfg_start);
         send_byte(len[15:8]);
         send_byte(len[7:0]);
         frame_items += 3;
         send_noise($urandom_range(0, 3));
      end else if (forced_len == 0 && pick < 25) begin
         send_noise($urandom_range(1, 4));
      end else begin
         top = (cfg_max > 40) ? 40 : int'(cfg_max);
         len = $urandom_range(sled_pkg::MIN_FRAME_LEN, top);
         if (pick >= 95 && cfg_max <= 64)
            len = int'(cfg_max);
         if (forced_len > 0)
            len = forced_len;
         send_byte(cfg_start);
         send_byte(len[15:8]);
         send_byte(len[7:0]);
         send_byte(8'($urandom_range(0, 255)));
         // Payload; a start byte inside the frame is ordinary data.
         for (int i = 0; i < len - 5; i++) begin
            b = ($urandom_range(0, 7) == 0) ? cfg_start : 8'($urandom_range(0, 255));
            send_byte(b);
         end
         b = ($urandom_range(0, 3) != 0) ? cfg_end : 8'($urandom_range(0, 255));
         send_byte(b);
         frame_items += len;
      end
   endtask

   initial begin
      int         budget;
      int         first;
      logic [7:0] rs;
      logic [7:0] re;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames at the reset settings.
      send_byte(8'h00);                       // noise while hunting
      send_byte(8'hFF);
      send_byte(8'hAA); send_byte(8'h00); send_byte(8'h05);   // shortest good frame
      send_byte(8'h3C); send_byte(8'hBB);
      send_byte(8'hAA); send_byte(8'h00); send_byte(8'h05);   // wrong end byte
      send_byte(8'hC3); send_byte(8'h00);
      send_byte(8'hAA); send_byte(8'h00); send_byte(8'h04);   // length too short
      send_byte(8'hAA); send_byte(8'h00); send_byte(8'h00);   // zero length
      send_byte(8'hAA); send_byte(8'h04); send_byte(8'h07);   // one above maximum
      send_byte(8'hAA); send_byte(8'h00); send_byte(8'h06);   // start byte as data
      send_byte(8'hAA); send_byte(8'hAA); send_byte(8'hBB);
      frame_items += 27;

      // Maximum lowered in the middle of a frame that already passed its check.
      send_byte(8'hAA); send_byte(8'h00); send_byte(8'h0A);
      send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
      drain();
      write_reg(sled_pkg::CSR_MAX_FRAME_LEN, 16'd5);
      csr_valid <= 1'b0;
      cfg_max = 16'd5;
      send_byte(8'h44); send_byte(8'h55); send_byte(8'h66); send_byte(8'hBB);
      frame_items += 10;
      drain();
      configure(sled_pkg::START_BYTE_RESET, sled_pkg::END_BYTE_RESET,
                sled_pkg::MAX_FRAME_LEN_RESET);

      // One frame longer than the random ones at the reset settings.
      send_frame(64);
      drain();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 7; phase++) begin
         rs = 8'($urandom_range(0, 255));
         re = 8'($urandom_range(0, 255));
         budget = 50;
         case (phase)
            0: begin
               configure(sled_pkg::START_BYTE_RESET, sled_pkg::END_BYTE_RESET,
                         sled_pkg::MAX_FRAME_LEN_RESET);
               budget = 70;
            end
            1: configure(8'h00, 8'hFF, 16'd5);
            2: begin
               write_reg(CSR_UNMAPPED, 16'($urandom_range(0, 65535)));
               configure(8'hFF, 8'h00, 16'hFFFF);
            end
            3: begin
               configure(rs, re, 16'd4);
               budget = 40;
            end
            4: begin
               configure(rs, re, 16'd0);
               budget = 25;
            end
            5: begin
               configure(rs, re, 16'($urandom_range(5, 64)));
               budget = 70;
            end
            default: configure(rs, re, 16'($urandom_range(65, 2000)));
         endcase
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         first = frame_items;
         while (frame_items - first < budget)
            send_frame(0);
         drain();
      end

      $display("Sent %0d frame bytes under %0d register settings.",
               frame_items, settings_used);
      $display("Checked %0d results: %0d good frames, %0d rejected frames.",
               sb.results_checked, sb.good_frames, sb.bad_frames);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("sof_length_eof_frame_deframer_core: match");
      end else begin
         $display("Mismatches: %0d, results still awaited: %0d",
                  sb.mismatches, sb.pending());
         $display("sof_length_eof_frame_deframer_core: mismatch");
      end
      $finish;
   end

endmodule
